[hw/rtl/running_leader_time_query_core_macros.svh]
// Assertion helpers shared by the RTL.
// Define ASSERT_OFF to compile the assertions away.
`ifndef RUNNING_LEADER_TIME_QUERY_CORE_MACROS_SVH
`define RUNNING_LEADER_TIME_QUERY_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define RLTQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rltq assertion failed");

// next-cycle implication
`define RLTQ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rltq assertion failed");

`else

`define RLTQ_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RLTQ_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

[hw/rtl/rltq_pkg.sv]
`timescale 1ns / 1ps

package rltq_pkg;

   localparam int CMD_W   = 2;
   localparam int ID_W    = 8;
   localparam int TIME_W  = 31;
   localparam int COUNT_W = 11;
   localparam int ERR_W   = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

   typedef logic [CMD_W-1:0] cmd_type;
   typedef logic [ERR_W-1:0] err_type;

   localparam cmd_type CMD_VOTE  = 2'd0;
   localparam cmd_type CMD_QUERY = 2'd1;
   localparam cmd_type CMD_CLEAR = 2'd2;

   localparam err_type ERR_OK    = 2'd0;
   localparam err_type ERR_FULL  = 2'd1;
   localparam err_type ERR_ORDER = 2'd2;

   typedef enum logic [2:0] {
      ST_WIPE,
      ST_IDLE,
      ST_VOTE,
      ST_SEARCH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0] leader_id;
      logic            found;
      err_type         error;
   } res_type;

endpackage

[hw/rtl/rltq_req_if.sv]
`timescale 1ns / 1ps

interface rltq_req_if;
   logic                         valid;
   logic                         ready;
   logic [rltq_pkg::CMD_W-1:0]   cmd;
   logic [rltq_pkg::ID_W-1:0]    person;
   logic [rltq_pkg::TIME_W-1:0]  timestamp;

   modport source (output valid, output cmd, output person, output timestamp, input ready);
   modport sink   (input valid, input cmd, input person, input timestamp, output ready);
endinterface

[hw/rtl/rltq_rsp_if.sv]
`timescale 1ns / 1ps

interface rltq_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rltq_pkg::ID_W-1:0]   leader_id;
   logic                        found;
   logic [rltq_pkg::ERR_W-1:0]  error;

   modport source (output valid, output leader_id, output found, output error, input ready);
   modport sink   (input valid, input leader_id, input found, input error, output ready);
endinterface

[hw/rtl/rltq_ram.sv]
`timescale 1ns / 1ps

module rltq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/rltq_ctrl.sv]
`timescale 1ns / 1ps
`include "running_leader_time_query_core_macros.svh"

module rltq_ctrl #(
   parameter int LOG_DEPTH      = 1024,
   parameter int NUM_CANDIDATES = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // item side
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  rltq_pkg::cmd_type                      in_cmd,
   input  logic [rltq_pkg::ID_W-1:0]              in_person,
   input  logic [rltq_pkg::TIME_W-1:0]            in_timestamp,
   // result side
   input  logic                                   out_free,
   output logic                                   res_valid,
   output rltq_pkg::res_type                      res,
   // counts memory
   output logic                                   cnt_we,
   output logic [$clog2(NUM_CANDIDATES)-1:0]      cnt_addr,
   output logic [rltq_pkg::COUNT_W-1:0]           cnt_wdata,
   input  logic [rltq_pkg::COUNT_W-1:0]           cnt_rdata,
   // time and leader log memory
   output logic                                   log_we,
   output logic [$clog2(LOG_DEPTH)-1:0]           log_addr,
   output logic [rltq_pkg::TIME_W+rltq_pkg::ID_W-1:0] log_wdata,
   input  logic [rltq_pkg::TIME_W+rltq_pkg::ID_W-1:0] log_rdata
);

   import rltq_pkg::*;

   localparam int CAND_W = $clog2(NUM_CANDIDATES);
   localparam int LOG_AW = $clog2(LOG_DEPTH);
   localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
   localparam int EXT_W  = (CAND_W > ID_W) ? CAND_W : ID_W;
   localparam int RED_W  = 20;

   // person modulo candidate count, restoring subtraction over the 8 bits
   function automatic logic [ID_W-1:0] reduce_id(input logic [ID_W-1:0] p);
      logic [RED_W-1:0] r;
      r = RED_W'(p);
      for (int k = ID_W - 1; k >= 0; k--) begin
         if (r >= (RED_W'(NUM_CANDIDATES) << k)) begin
            r = r - (RED_W'(NUM_CANDIDATES) << k);
         end
      end
      return r[ID_W-1:0];
   endfunction

   state_type          state_ff, state_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [CNT_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;
   logic [CNT_W-1:0]   mid_ff, mid_in;
   logic [ID_W-1:0]    ans_ff, ans_in;
   logic [CNT_W-1:0]   votes_ff, votes_in;
   logic [COUNT_W-1:0] top_ff, top_in;
   logic [ID_W-1:0]    lead_ff, lead_in;
   logic [TIME_W-1:0]  last_ff, last_in;
   logic [CAND_W-1:0]  wipe_ff, wipe_in;
   logic               wipe_rsp_ff, wipe_rsp_in;
   res_type            res_ff, res_in;

   logic               in_fire;
   logic               log_full;
   logic               out_of_order;
   logic [ID_W-1:0]    red_id;
   logic [EXT_W-1:0]   red_ext;
   logic [EXT_W-1:0]   id_ext;
   logic [TIME_W-1:0]  rd_time;
   logic [ID_W-1:0]    rd_lead;
   logic               le;
   logic [CNT_W-1:0]   lo_nx;
   logic [CNT_W-1:0]   hi_nx;
   logic [CNT_W-1:0]   mid_nx;
   logic               more;
   logic [CNT_W-1:0]   mid_first;
   logic [COUNT_W-1:0] cnt_inc;
   logic               takes_lead;
   logic [ID_W-1:0]    new_lead;
   logic               wipe_last;

   assign in_fire      = in_valid && in_ready;
   assign log_full     = (votes_ff == CNT_W'(LOG_DEPTH));
   assign out_of_order = (votes_ff != '0) && (in_timestamp <= last_ff);
   assign red_id       = reduce_id(in_person);
   assign red_ext      = EXT_W'(red_id);
   assign id_ext       = EXT_W'(id_ff);
   assign mid_first    = votes_ff >> 1;

   // search step on the entry read last cycle
   assign rd_time = log_rdata[TIME_W+ID_W-1:ID_W];
   assign rd_lead = log_rdata[ID_W-1:0];
   assign le      = (rd_time <= time_ff);
   assign lo_nx   = le ? (mid_ff + CNT_W'(1)) : lo_ff;
   assign hi_nx   = le ? hi_ff : mid_ff;
   assign more    = (lo_nx < hi_nx);
   assign mid_nx  = lo_nx + ((hi_nx - lo_nx) >> 1);

   // vote update
   assign cnt_inc    = (cnt_rdata == COUNT_MAX) ? cnt_rdata : (cnt_rdata + COUNT_W'(1));
   assign takes_lead = (cnt_inc >= top_ff);
   assign new_lead   = takes_lead ? id_ff : lead_ff;

   assign wipe_last = (wipe_ff == CAND_W'(NUM_CANDIDATES - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_WIPE: begin
            if (wipe_last) begin
               state_in = wipe_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (in_fire) begin
               priority if (in_cmd == CMD_VOTE) begin
                  state_in = (log_full || out_of_order) ? ST_DONE : ST_VOTE;
               end else if (in_cmd == CMD_QUERY) begin
                  state_in = (votes_ff == '0) ? ST_DONE : ST_SEARCH;
               end else if (in_cmd == CMD_CLEAR) begin
                  state_in = ST_WIPE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_VOTE: begin
            state_in = ST_DONE;
         end
         ST_SEARCH: begin
            if (!more) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // memory controls and handshake
   always_comb begin
      in_ready  = 1'b0;
      res_valid = 1'b0;
      cnt_we    = 1'b0;
      cnt_addr  = red_ext[CAND_W-1:0];
      cnt_wdata = '0;
      log_we    = 1'b0;
      log_addr  = mid_first[LOG_AW-1:0];
      log_wdata = {time_ff, new_lead};
      unique case (state_ff)
         ST_WIPE: begin
            cnt_we   = 1'b1;
            cnt_addr = wipe_ff;
         end
         ST_IDLE: begin
            in_ready = 1'b1;
         end
         ST_VOTE: begin
            cnt_we    = 1'b1;
            cnt_addr  = id_ext[CAND_W-1:0];
            cnt_wdata = cnt_inc;
            log_we    = 1'b1;
            log_addr  = votes_ff[LOG_AW-1:0];
         end
         ST_SEARCH: begin
            log_addr = mid_nx[LOG_AW-1:0];
         end
         ST_DONE: begin
            res_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // datapath registers
   always_comb begin
      time_in     = time_ff;
      id_in       = id_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      ans_in      = ans_ff;
      votes_in    = votes_ff;
      top_in      = top_ff;
      lead_in     = lead_ff;
      last_in     = last_ff;
      wipe_in     = wipe_ff;
      wipe_rsp_in = wipe_rsp_ff;
      res_in      = res_ff;
      unique case (state_ff)
         ST_WIPE: begin
            wipe_in = wipe_ff + CAND_W'(1);
         end
         ST_IDLE: begin
            if (in_fire) begin
               time_in = in_timestamp;
               id_in   = red_id;
               res_in  = '{leader_id: '0, found: 1'b0, error: ERR_OK};
               priority if (in_cmd == CMD_VOTE) begin
                  if (log_full) begin
                     res_in = '{leader_id: lead_ff, found: 1'b1, error: ERR_FULL};
                  end else if (out_of_order) begin
                     res_in = '{leader_id: lead_ff, found: 1'b1, error: ERR_ORDER};
                  end
               end else if (in_cmd == CMD_QUERY) begin
                  lo_in  = '0;
                  hi_in  = votes_ff;
                  mid_in = mid_first;
               end else if (in_cmd == CMD_CLEAR) begin
                  votes_in    = '0;
                  top_in      = '0;
                  lead_in     = '0;
                  wipe_in     = '0;
                  wipe_rsp_in = 1'b1;
               end else begin
               end
            end
         end
         ST_VOTE: begin
            if (takes_lead) begin
               top_in  = cnt_inc;
               lead_in = id_ff;
            end
            votes_in = votes_ff + CNT_W'(1);
            last_in  = time_ff;
            res_in   = '{leader_id: new_lead, found: 1'b1, error: ERR_OK};
         end
         ST_SEARCH: begin
            lo_in  = lo_nx;
            hi_in  = hi_nx;
            mid_in = mid_nx;
            if (le) begin
               ans_in = rd_lead;
            end
            if (!more) begin
               res_in = '{leader_id: (lo_nx == '0) ? '0 : (le ? rd_lead : ans_ff),
                          found: (lo_nx != '0), error: ERR_OK};
            end
         end
         ST_DONE: begin
            wipe_rsp_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_WIPE;
         wipe_ff     <= '0;
         wipe_rsp_ff <= 1'b0;
         votes_ff    <= '0;
         top_ff      <= '0;
         lead_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         wipe_ff     <= wipe_in;
         wipe_rsp_ff <= wipe_rsp_in;
         votes_ff    <= votes_in;
         top_ff      <= top_in;
         lead_ff     <= lead_in;
      end
      time_ff <= time_in;
      id_ff   <= id_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      ans_ff  <= ans_in;
      last_ff <= last_in;
      res_ff  <= res_in;
   end

   assign res = res_ff;

   `RLTQ_ASSERT_IMP(a_log_bound, clock, reset, 1'b1, votes_ff <= CNT_W'(LOG_DEPTH))
   `RLTQ_ASSERT_IMP(a_search_window, clock, reset, state_ff == ST_SEARCH, lo_ff < hi_ff)
   `RLTQ_ASSERT_IMP(a_search_mid, clock, reset, state_ff == ST_SEARCH, mid_ff < votes_ff)
   `RLTQ_ASSERT_NXT(a_leave_idle, clock, reset, in_fire, state_ff != ST_IDLE)
   `RLTQ_ASSERT_IMP(a_vote_room, clock, reset, state_ff == ST_VOTE, votes_ff < CNT_W'(LOG_DEPTH))

endmodule

[hw/rtl/running_leader_time_query_core.sv]
`timescale 1ns / 1ps
// Channel   Dir   Beat payload                         Accepted when
// req_bus   in    cmd[1:0] person[7:0] timestamp[30:0]  valid && ready
// rsp_bus   out   leader_id[7:0] found error[1:0]      valid && ready
//
// Vote: accept and counts read, then count and log write-back, then result
//    hand-off; a dropped vote, an empty-log query or cmd 3 skips to hand-off.
// Query: accept, then a binary search of the log with one probe of the log
//    memory per cycle, then result hand-off.
// Reset and clear: a wipe sweeps every entry of the counts memory, during
//    which no item is taken; a clear answers after its wipe.
// A result waiting on rsp_bus does not stop the next req_bus beat from being
//    accepted; only the following result holds until the output drains.
module running_leader_time_query_core #(
   parameter int LOG_DEPTH      = 1024,
   parameter int NUM_CANDIDATES = 256
) (
   input logic        clock,
   input logic        reset,
   rltq_req_if.sink   req_bus,
   rltq_rsp_if.source rsp_bus
);

   import rltq_pkg::*;

   localparam int CAND_W = $clog2(NUM_CANDIDATES);
   localparam int LOG_AW = $clog2(LOG_DEPTH);
   localparam int LOG_W  = TIME_W + ID_W;

   // controller to output stage
   logic    out_free;
   logic    res_valid;
   res_type res;

   // counts memory port
   logic               cnt_we;
   logic [CAND_W-1:0]  cnt_addr;
   logic [COUNT_W-1:0] cnt_wdata;
   logic [COUNT_W-1:0] cnt_rdata;

   // log memory port: timestamp in the upper bits, leader below
   logic              log_we;
   logic [LOG_AW-1:0] log_addr;
   logic [LOG_W-1:0]  log_wdata;
   logic [LOG_W-1:0]  log_rdata;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_data_ff, rsp_data_in;
   logic    rsp_load;

   rltq_ctrl #(
      .LOG_DEPTH      (LOG_DEPTH),
      .NUM_CANDIDATES (NUM_CANDIDATES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_bus.valid),
      .in_ready     (req_bus.ready),
      .in_cmd       (req_bus.cmd),
      .in_person    (req_bus.person),
      .in_timestamp (req_bus.timestamp),
      .out_free     (out_free),
      .res_valid    (res_valid),
      .res          (res),
      .cnt_we       (cnt_we),
      .cnt_addr     (cnt_addr),
      .cnt_wdata    (cnt_wdata),
      .cnt_rdata    (cnt_rdata),
      .log_we       (log_we),
      .log_addr     (log_addr),
      .log_wdata    (log_wdata),
      .log_rdata    (log_rdata)
   );

   // per-candidate vote counts, cleared by the wipe sweep
   rltq_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (NUM_CANDIDATES)
   ) u_cnt_ram (
      .clock (clock),
      .we    (cnt_we),
      .addr  (cnt_addr),
      .wdata (cnt_wdata),
      .rdata (cnt_rdata)
   );

   // vote log; only entries below the fill count are ever probed
   rltq_ram #(
      .WIDTH (LOG_W),
      .DEPTH (LOG_DEPTH)
   ) u_log_ram (
      .clock (clock),
      .we    (log_we),
      .addr  (log_addr),
      .wdata (log_wdata),
      .rdata (log_rdata)
   );

   // take a new result when the register is empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_load = res_valid && out_free;

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_data_in  = res;
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.leader_id = rsp_data_ff.leader_id;
   assign rsp_bus.found     = rsp_data_ff.found;
   assign rsp_bus.error     = rsp_data_ff.error;

endmodule
